### rtl/core/xna_pkg.sv
package xna_pkg;

    localparam int GRID_SIDE = 64;
    localparam int ROW_W     = 6;
    localparam int SIDE_W    = 7;
    localparam int ADDR_W    = ROW_W + 1;
    localparam int RULE_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    typedef logic [GRID_SIDE-1:0] row_t;
    typedef logic [ROW_W-1:0]     idx_t;
    typedef logic [SIDE_W-1:0]    side_t;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_MASK    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SIDE = 1'b1;

    // true when idx lies in [org, org + side)
    function automatic logic in_square(idx_t idx, idx_t org, side_t side);
        logic [SIDE_W:0] hi;
        hi = {2'b00, org} + {1'b0, side};
        return ({2'b00, idx} >= {2'b00, org}) && ({2'b00, idx} < hi);
    endfunction

    // one bit per column inside the active square
    function automatic row_t square_cols(idx_t org, side_t side);
        row_t m;
        for (int c = 0; c < GRID_SIDE; c++)
        begin
            m[c] = in_square(idx_t'(c), org, side);
        end
        return m;
    endfunction

endpackage

### rtl/core/xna_cell_mem.sv
module xna_cell_mem (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [xna_pkg::ADDR_W-1:0] wr_addr,
    input  xna_pkg::row_t         wr_data,
    input  logic                  rd_en,
    input  logic [xna_pkg::ADDR_W-1:0] rd_addr,
    output xna_pkg::row_t         rd_data
);
    import xna_pkg::*;

    // two banks of GRID_SIDE rows, bank select is the address msb
    row_t mem [2**ADDR_W];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/xna_row_engine.sv
module xna_row_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr,
    input  logic                       shift,
    input  logic [xna_pkg::RULE_W-1:0] rule_mask,
    input  xna_pkg::row_t              below_row,
    output xna_pkg::row_t              new_row
);
    import xna_pkg::*;

    row_t above_reg;
    row_t mid_reg;
    logic [GRID_SIDE+1:0] a;
    logic [GRID_SIDE+1:0] m;
    logic [GRID_SIDE+1:0] b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= '0;
            mid_reg   <= '0;
        end
        else if (clr)
        begin
            above_reg <= '0;
            mid_reg   <= '0;
        end
        else if (shift)
        begin
            above_reg <= mid_reg;
            mid_reg   <= below_row;
        end
    end

    // zero pad on both edges, column c sits at c+1
    assign a = {1'b0, above_reg, 1'b0};
    assign m = {1'b0, mid_reg, 1'b0};
    assign b = {1'b0, below_row, 1'b0};

    always_comb
    begin
        for (int c = 0; c < GRID_SIDE; c++)
        begin
            new_row[c] = (rule_mask[0] & m[c+1]) ^ (rule_mask[1] & m[c+2])
                       ^ (rule_mask[2] & b[c+2]) ^ (rule_mask[3] & b[c+1])
                       ^ (rule_mask[4] & b[c])   ^ (rule_mask[5] & m[c])
                       ^ (rule_mask[6] & a[c])   ^ (rule_mask[7] & a[c+1])
                       ^ (rule_mask[8] & a[c+2]);
        end
    end

endmodule

### rtl/core/xor_neighbourhood_automaton_2d_top.sv
// channel    direction  signals                                   beat taken when
// command    in         start, busy, mode, row, col, cell_value   start & !busy
// result     out        done, read_value, active_side,            done (one cycle)
//                       growth_limited, coord_error
// config     in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// a read or write first reads the row, then a write puts the row back with the bit updated; a coordinate
// error is answered without a memory access; a step passes one 64-cell row per cycle through the row
// engine once its window has filled; a clear zeroes one row per cycle
// after reset a clearing pass zeroes bank a, busy stays high meanwhile
// the result beat is shown for one cycle and cannot be stalled
module xor_neighbourhood_automaton_2d_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [xna_pkg::ROW_W-1:0]         row,
    input  logic [xna_pkg::ROW_W-1:0]         col,
    input  logic                              cell_value,
    output logic                              done,
    output logic                              read_value,
    output logic [xna_pkg::SIDE_W-1:0]        active_side,
    output logic                              growth_limited,
    output logic                              coord_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [xna_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [xna_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import xna_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    localparam side_t RESET_SIDE = side_t'(8);
    localparam idx_t  RESET_ORG  = idx_t'((GRID_SIDE - 8) / 2);
    localparam logic [SIDE_W:0] GRID_LIM = (SIDE_W+1)'(GRID_SIDE);
    localparam logic [SIDE_W:0] STEP_LAST = (SIDE_W+1)'(GRID_SIDE + 1);

    logic [1:0]        state_reg, state_next;
    logic [SIDE_W:0]   cnt_reg, cnt_next;
    logic              bank_reg, bank_next;
    side_t             side_reg, side_next;
    idx_t              org_reg, org_next;
    side_t             nside_reg, nside_next;
    idx_t              norg_reg, norg_next;
    logic              lim_reg, lim_next;
    logic              clr_cmd_reg, clr_cmd_next;
    logic              is_wr_reg, is_wr_next;
    idx_t              arow_reg, arow_next;
    idx_t              acol_reg, acol_next;
    logic              val_reg, val_next;
    logic [RULE_W-1:0] rule_reg;
    side_t             init_reg;

    logic              done_reg, done_next;
    logic              rv_reg, rv_next;
    side_t             aside_reg, aside_next;
    logic              gl_reg, gl_next;
    logic              ce_reg, ce_next;

    // memory and engine hookup
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    row_t                mem_wdata, mem_rdata;
    logic                eng_clr, eng_shift;
    row_t                below_row, new_row;

    // step scratch
    idx_t                in_idx, out_idx;
    side_t               clamp_side;
    logic [SIDE_W:0]     grow_end;

    xna_cell_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    xna_row_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (eng_clr),
        .shift     (eng_shift),
        .rule_mask (rule_reg),
        .below_row (below_row),
        .new_row   (new_row)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // initial side clamped to 1..GRID_SIDE
    always_comb
    begin
        if (init_reg == '0)
            clamp_side = side_t'(1);
        else if ({1'b0, init_reg} > GRID_LIM)
            clamp_side = side_t'(GRID_SIDE);
        else
            clamp_side = init_reg;
    end

    assign grow_end = {2'b00, org_reg} + {1'b0, side_reg} + (SIDE_W+1)'(1);
    // row arriving from memory during a step and row being written out
    assign in_idx  = idx_t'(cnt_reg - (SIDE_W+1)'(1));
    assign out_idx = idx_t'(cnt_reg - (SIDE_W+1)'(2));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bank_next    = bank_reg;
        side_next    = side_reg;
        org_next     = org_reg;
        nside_next   = nside_reg;
        norg_next    = norg_reg;
        lim_next     = lim_reg;
        clr_cmd_next = clr_cmd_reg;
        is_wr_next   = is_wr_reg;
        arow_next    = arow_reg;
        acol_next    = acol_reg;
        val_next     = val_reg;
        done_next    = 1'b0;
        rv_next      = rv_reg;
        aside_next   = aside_reg;
        gl_next      = gl_reg;
        ce_next      = ce_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = {bank_reg, arow_reg};
        mem_raddr    = {bank_reg, row};
        mem_wdata    = mem_rdata;
        eng_clr      = 1'b0;
        eng_shift    = 1'b0;
        below_row    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_WRITE, MODE_READ:
                        begin
                            if ({1'b0, row} >= side_reg || {1'b0, col} >= side_reg)
                            begin
                                done_next  = 1'b1;
                                rv_next    = 1'b0;
                                aside_next = side_reg;
                                gl_next    = 1'b0;
                                ce_next    = 1'b1;
                            end
                            else
                            begin
                                arow_next  = org_reg + row;
                                acol_next  = org_reg + col;
                                is_wr_next = (mode == MODE_WRITE);
                                val_next   = cell_value;
                                mem_re     = 1'b1;
                                mem_raddr  = {bank_reg, org_reg + row};
                                state_next = ST_ACC;
                            end
                        end
                        MODE_STEP:
                        begin
                            if (org_reg != '0 && grow_end <= GRID_LIM)
                            begin
                                norg_next  = org_reg - idx_t'(1);
                                nside_next = side_reg + side_t'(2);
                                lim_next   = 1'b0;
                            end
                            else
                            begin
                                norg_next  = org_reg;
                                nside_next = side_reg;
                                lim_next   = 1'b1;
                            end
                            cnt_next   = '0;
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            side_next    = clamp_side;
                            org_next     = idx_t'((side_t'(GRID_SIDE) - clamp_side) >> 1);
                            bank_next    = 1'b0;
                            cnt_next     = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLR;
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                // read of one row, written back with the new bit on a write
                mem_we    = is_wr_reg;
                mem_waddr = {bank_reg, arow_reg};
                mem_wdata = mem_rdata;
                mem_wdata[acol_reg] = val_reg;
                done_next  = 1'b1;
                rv_next    = is_wr_reg ? 1'b0 : mem_rdata[acol_reg];
                aside_next = side_reg;
                gl_next    = 1'b0;
                ce_next    = 1'b0;
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                eng_clr   = (cnt_reg == '0);
                eng_shift = (cnt_reg != '0);
                if (cnt_reg < GRID_LIM)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {bank_reg, idx_t'(cnt_reg)};
                end
                // cells outside the old square read as zero
                if (cnt_reg != '0 && cnt_reg <= GRID_LIM && in_square(in_idx, org_reg, side_reg))
                begin
                    below_row = mem_rdata & square_cols(org_reg, side_reg);
                end
                if (cnt_reg >= (SIDE_W+1)'(2))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {~bank_reg, out_idx};
                    mem_wdata = in_square(out_idx, norg_reg, nside_reg)
                              ? (new_row & square_cols(norg_reg, nside_reg)) : '0;
                end
                cnt_next = cnt_reg + (SIDE_W+1)'(1);
                if (cnt_reg == STEP_LAST)
                begin
                    bank_next  = ~bank_reg;
                    side_next  = nside_reg;
                    org_next   = norg_reg;
                    done_next  = 1'b1;
                    rv_next    = 1'b0;
                    aside_next = nside_reg;
                    gl_next    = lim_reg;
                    ce_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                // bank a zeroed one row per cycle
                mem_we    = 1'b1;
                mem_waddr = {1'b0, idx_t'(cnt_reg)};
                mem_wdata = '0;
                cnt_next  = cnt_reg + (SIDE_W+1)'(1);
                if (cnt_reg == GRID_LIM - (SIDE_W+1)'(1))
                begin
                    done_next    = clr_cmd_reg;
                    rv_next      = 1'b0;
                    aside_next   = side_reg;
                    gl_next      = 1'b0;
                    ce_next      = 1'b0;
                    clr_cmd_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            bank_reg    <= 1'b0;
            side_reg    <= RESET_SIDE;
            org_reg     <= RESET_ORG;
            clr_cmd_reg <= 1'b0;
            done_reg    <= 1'b0;
            rule_reg    <= '0;
            init_reg    <= RESET_SIDE;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            bank_reg    <= bank_next;
            side_reg    <= side_next;
            org_reg     <= org_next;
            clr_cmd_reg <= clr_cmd_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RULE_MASK:    rule_reg <= cfg_data[RULE_W-1:0];
                    CFG_INITIAL_SIDE: init_reg <= cfg_data[SIDE_W-1:0];
                    default:          rule_reg <= rule_reg;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        nside_reg <= nside_next;
        norg_reg  <= norg_next;
        lim_reg   <= lim_next;
        is_wr_reg <= is_wr_next;
        arow_reg  <= arow_next;
        acol_reg  <= acol_next;
        val_reg   <= val_next;
        rv_reg    <= rv_next;
        aside_reg <= aside_next;
        gl_reg    <= gl_next;
        ce_reg    <= ce_next;
    end

    assign done           = done_reg;
    assign read_value     = rv_reg;
    assign active_side    = aside_reg;
    assign growth_limited = gl_reg;
    assign coord_error    = ce_reg;

endmodule

### tb/tb_xor_neighbourhood_automaton_2d_top.sv
module tb_xor_neighbourhood_automaton_2d_top;
    import xna_pkg::*;

    // cycle budget: about 140 items, steps and clears among them,
    // plus config pauses stay far below this
    localparam int CYCLE_LIMIT = 200000;
    // pause before a config write, covers the longest command latency
    localparam int IDLE_PAUSE  = 80;

    typedef struct packed {
        logic       read_value;
        side_t      active_side;
        logic       growth_limited;
        logic       coord_error;
    } outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      col;
    logic                  cell_value;
    logic                  done;
    logic                  read_value;
    logic [SIDE_W-1:0]     active_side;
    logic                  growth_limited;
    logic                  coord_error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    xor_neighbourhood_automaton_2d_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .row            (row),
        .col            (col),
        .cell_value     (cell_value),
        .done           (done),
        .read_value     (read_value),
        .active_side    (active_side),
        .growth_limited (growth_limited),
        .coord_error    (coord_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // predicted automaton state: one live grid, cells outside the square kept zero
    bit          grid [GRID_SIDE][GRID_SIDE];
    int          side_live;
    int          origin_live;
    logic [8:0]  rule_live;
    logic [6:0]  init_side_live;

    outcome_t    pending_outcomes [$];
    int          fail_count;
    int          cycle_count;

    // neighbour offsets per rule bit: centre, E, SE, S, SW, W, NW, N, NE
    const int nb_dcol [9] = '{0, 1, 1, 0, -1, -1, -1, 0, 1};
    const int nb_drow [9] = '{0, 0, 1, 1, 1, 0, -1, -1, -1};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // wipe the grid and recentre at the clamped initial side
    function automatic void clear_grid_model();
        int s;
        s = init_side_live;
        if (s < 1)
            s = 1;
        if (s > GRID_SIDE)
            s = GRID_SIDE;
        foreach (grid[r, c])
            grid[r][c] = 1'b0;
        side_live   = s;
        origin_live = (GRID_SIDE - s) / 2;
    endfunction

    // one generation; returns 1 when the square could not grow
    function automatic bit step_grid_model();
        bit limited;
        bit nxt [GRID_SIDE][GRID_SIDE];
        bit acc;
        int nr;
        int nc;
        limited = !(origin_live >= 1 && origin_live + side_live + 1 <= GRID_SIDE);
        if (!limited)
        begin
            origin_live -= 1;
            side_live   += 2;
        end
        foreach (nxt[r, c])
            nxt[r][c] = 1'b0;
        for (int r = 0; r < side_live; r++)
        begin
            for (int c = 0; c < side_live; c++)
            begin
                acc = 1'b0;
                for (int k = 0; k < 9; k++)
                begin
                    nr = r + nb_drow[k];
                    nc = c + nb_dcol[k];
                    if (rule_live[k] && nr >= 0 && nr < side_live && nc >= 0
                        && nc < side_live)
                        acc ^= grid[origin_live + nr][origin_live + nc];
                end
                nxt[origin_live + r][origin_live + c] = acc;
            end
        end
        grid = nxt;
        return limited;
    endfunction

    // expected outcome of one command, updating the predicted state
    function automatic outcome_t predict_outcome(logic [1:0] m, int r, int c, bit v);
        outcome_t o;
        o = '0;
        if (m == MODE_WRITE || m == MODE_READ)
        begin
            if (r >= side_live || c >= side_live)
                o.coord_error = 1'b1;
            else if (m == MODE_WRITE)
                grid[origin_live + r][origin_live + c] = v;
            else
                o.read_value = grid[origin_live + r][origin_live + c];
        end
        else if (m == MODE_STEP)
            o.growth_limited = step_grid_model();
        else
            clear_grid_model();
        o.active_side = side_t'(side_live);
        return o;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        fail_count++;
    endtask

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // drive one command beat and hold it until taken
    task automatic send_cmd(logic [1:0] m, int r, int c, bit v);
        int gap;
        start      <= 1'b1;
        mode       <= m;
        row        <= ROW_W'(r);
        col        <= ROW_W'(c);
        cell_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(predict_outcome(m, r, c, v));
        gap = pick_gap();
        // zero gap keeps start high for the next beat
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // config writes only once every result is back and the block has settled
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_RULE_MASK)
            rule_live = 9'(data);
        else
            init_side_live = 7'(data);
    endtask

    // random command mix: mostly in-range accesses, some steps, clears and
    // out-of-range coordinates
    task automatic run_random(int count);
        int p;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 38)
                send_cmd(MODE_WRITE, $urandom_range(0, side_live - 1),
                         $urandom_range(0, side_live - 1), $urandom_range(0, 1));
            else if (p < 66)
                send_cmd(MODE_READ, $urandom_range(0, side_live - 1),
                         $urandom_range(0, side_live - 1), $urandom_range(0, 1));
            else if (p < 78)
                send_cmd(($urandom_range(0, 1) != 0) ? MODE_READ : MODE_WRITE,
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            else if (p < 94)
                send_cmd(MODE_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            else
                send_cmd(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
        end
    endtask

    // corners, out-of-range coordinates, every mode, growth from reset size
    task automatic test_directed_access();
        send_cmd(MODE_READ, 0, 0, 1'b0);
        send_cmd(MODE_WRITE, 0, 0, 1'b1);
        send_cmd(MODE_WRITE, 7, 7, 1'b1);
        send_cmd(MODE_WRITE, 3, 4, 1'b1);
        send_cmd(MODE_READ, 0, 0, 1'b0);
        send_cmd(MODE_READ, 7, 7, 1'b0);
        send_cmd(MODE_WRITE, 8, 0, 1'b1);
        send_cmd(MODE_READ, 0, 63, 1'b0);
        send_cmd(MODE_WRITE, 63, 63, 1'b1);
        send_cmd(MODE_WRITE, 0, 0, 1'b0);
        // rule mask still zero: step wipes the grid
        send_cmd(MODE_STEP, 0, 0, 1'b0);
        send_cmd(MODE_READ, 4, 5, 1'b0);
        send_cmd(MODE_CLEAR, 63, 63, 1'b1);
        send_cmd(MODE_READ, 3, 4, 1'b0);
    endtask

    // full rule, then grow to the store edge so growth saturates
    task automatic test_growth_limit();
        write_reg(CFG_RULE_MASK, 9'h1FF);
        send_cmd(MODE_WRITE, 3, 3, 1'b1);
        send_cmd(MODE_WRITE, 4, 5, 1'b1);
        for (int i = 0; i < 30; i++)
            send_cmd(MODE_STEP, 0, 0, 1'b0);
        send_cmd(MODE_READ, 63, 63, 1'b0);
        send_cmd(MODE_READ, 31, 32, 1'b0);
    endtask

    // initial side extremes including out-of-range values that clamp
    task automatic test_initial_side();
        int sides [5] = '{0, 1, 64, 127, 65};
        write_reg(CFG_RULE_MASK, 9'b010101010);
        foreach (sides[i])
        begin
            write_reg(CFG_INITIAL_SIDE, sides[i]);
            send_cmd(MODE_CLEAR, 0, 0, 1'b0);
            send_cmd(MODE_WRITE, side_live - 1, 0, 1'b1);
            send_cmd(MODE_STEP, 0, 0, 1'b0);
            send_cmd(MODE_READ, 0, 0, 1'b0);
        end
    endtask

    // random traffic under several rules and sizes
    task automatic test_random_rules();
        int rules [4] = '{9'h001, 9'h0AA, 9'h155, 9'h1FF};
        int isides [4] = '{2, 13, 5, 31};
        foreach (rules[i])
        begin
            write_reg(CFG_RULE_MASK, (i == 0) ? rules[i] : $urandom_range(0, 511));
            write_reg(CFG_INITIAL_SIDE, isides[i]);
            send_cmd(MODE_CLEAR, 0, 0, 1'b0);
            run_random(17);
        end
    endtask

    // result beats cannot be stalled: check every done cycle
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (active_side !== want.active_side)
                    report_mismatch("active_side", active_side, want.active_side);
                if (growth_limited !== want.growth_limited)
                    report_mismatch("growth_limited", growth_limited,
                                    want.growth_limited);
                if (coord_error !== want.coord_error)
                    report_mismatch("coord_error", coord_error, want.coord_error);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_WRITE;
        row         = '0;
        col         = '0;
        cell_value  = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_RULE_MASK;
        cfg_data    = '0;
        fail_count  = 0;
        cycle_count = 0;
        rule_live      = 9'd0;
        init_side_live = 7'd8;
        clear_grid_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_access();
        test_growth_limit();
        test_initial_side();
        test_random_rules();

        // drain outstanding results, then let the block settle
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### xor_neighbourhood_automaton_2d_top.f
rtl/core/xna_pkg.sv
rtl/core/xna_cell_mem.sv
rtl/core/xna_row_engine.sv
rtl/core/xor_neighbourhood_automaton_2d_top.sv
tb/tb_xor_neighbourhood_automaton_2d_top.sv
